/* design/ept_pkg.sv */
// Shared types and constants for the four-level translation table walker.
// Holds table geometry, entry bit layout, status and op codes, transaction structs.
// No dependencies.
package ept_pkg;

	// Table geometry
	localparam int TABLE_FRAMES      = 16;
	localparam int ENTRIES_PER_FRAME = 512;
	localparam int IDX_W             = $clog2(ENTRIES_PER_FRAME);
	localparam int FRAME_W           = $clog2(TABLE_FRAMES);
	localparam int NF_W              = FRAME_W + 1;
	localparam int TBL_DEPTH         = TABLE_FRAMES * ENTRIES_PER_FRAME;
	localparam int TBL_AW            = FRAME_W + IDX_W;

	// Field widths
	localparam int ENTRY_W = 64;
	localparam int PAGE_W  = 40;
	localparam int GADDR_W = 48;
	localparam int HADDR_W = 52;
	localparam int OFFS_W  = 12;

	// Entry bits
	localparam logic [ENTRY_W-1:0] BIT_R    = 64'h1;
	localparam logic [ENTRY_W-1:0] BIT_W    = 64'h2;
	localparam logic [ENTRY_W-1:0] BIT_X    = 64'h4;
	localparam logic [ENTRY_W-1:0] BIT_IPAT = 64'h40;
	localparam logic [ENTRY_W-1:0] BIT_UX   = 64'h400;
	localparam logic [ENTRY_W-1:0] MT_WB    = 64'h30; // type 6 in bits 5:3

	// Op codes
	localparam logic OP_MAP   = 1'b0;
	localparam logic OP_XLATE = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNMAPPED = 2'd1;
	localparam logic [1:0] ST_NOFRAME  = 2'd2;

	// Walk levels
	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD   = 2'd2;
	localparam logic [1:0] LVL_PT   = 2'd3;

	typedef struct packed {
		logic               op;
		logic [GADDR_W-1:0] guest_addr;
		logic [PAGE_W-1:0]  host_page;
		logic               write_back;
	} ept_req_t;

	typedef struct packed {
		logic [HADDR_W-1:0] host_addr;
		logic [1:0]         status;
	} ept_rsp_t;

endpackage

/* design/ept_four_level_map_and_walk.sv */
// Map: the result strobe comes from the leaf read state, which writes the leaf; translate: from the leaf evaluate.
// A walk that stops at level k (0 to 2) on an out-of-range link, on a missing
// link (translate only) or on an empty frame pool strobes from that level's evaluate.
// One transaction at a time, each level a read and an evaluate state on the single
// table port (a map's leaf level has only the read).
// After reset a clearing pass zeroes all 8192 table entries with busy high.
module ept_four_level_map_and_walk (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ept_pkg::ept_req_t req,
	output logic             done,
	output ept_pkg::ept_rsp_t rsp
);
	import ept_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;

	logic [2:0]         state_q;
	logic [1:0]         level_q;
	logic [FRAME_W-1:0] frame_q;
	logic [NF_W-1:0]    nfree_q;
	logic [TBL_AW-1:0]  clr_q;
	ept_req_t           req_q;
	ept_rsp_t           rsp_q;
	logic               done_q;

	logic               ram_we;
	logic [TBL_AW-1:0]  ram_addr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	logic [IDX_W-1:0]   idx;
	logic               present;
	logic [PAGE_W-1:0]  ent_page;
	logic               link_bad;
	logic               pool_empty;
	logic [ENTRY_W-1:0] link_entry;
	logic [ENTRY_W-1:0] leaf_entry;

	// Pick the 9-bit index for the current level
	always_comb begin
		unique case (level_q)
			LVL_PML4: idx = req_q.guest_addr[47:39];
			LVL_PDPT: idx = req_q.guest_addr[38:30];
			LVL_PD:   idx = req_q.guest_addr[29:21];
			LVL_PT:   idx = req_q.guest_addr[20:12];
			default:  idx = '0;
		endcase
	end

	// Decode the entry just read
	assign present    = |ram_rdata[2:0];
	assign ent_page   = ram_rdata[OFFS_W +: PAGE_W];
	assign link_bad   = ent_page >= PAGE_W'(TABLE_FRAMES);
	assign pool_empty = nfree_q >= NF_W'(TABLE_FRAMES);

	// Build the entries that map writes
	assign link_entry = BIT_R | BIT_W | BIT_X | BIT_UX |
		{{(ENTRY_W-OFFS_W-FRAME_W){1'b0}}, nfree_q[FRAME_W-1:0], {OFFS_W{1'b0}}};
	assign leaf_entry = BIT_R | BIT_W | BIT_X | BIT_UX | BIT_IPAT |
		(req_q.write_back ? MT_WB : '0) |
		{{(ENTRY_W-OFFS_W-PAGE_W){1'b0}}, req_q.host_page, {OFFS_W{1'b0}}};

	// Drive the table port
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = {frame_q, idx};
		ram_wdata = link_entry;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			S_READ: begin
				if (level_q == LVL_PT && req_q.op == OP_MAP) begin
					ram_we    = 1'b1;
					ram_wdata = leaf_entry;
				end
			end
			S_EVAL: begin
				if (level_q != LVL_PT && !present && req_q.op == OP_MAP && !pool_empty) begin
					ram_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	ept_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TBL_DEPTH)
	) u_tbl (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
	end

	// Sequencer: clear, then walk one level per read/evaluate pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			level_q <= LVL_PML4;
			frame_q <= '0;
			nfree_q <= NF_W'(1);
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TBL_AW'(TBL_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						level_q <= LVL_PML4;
						frame_q <= '0;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (level_q == LVL_PT && req_q.op == OP_MAP) begin
						rsp_q   <= '{host_addr: '0, status: ST_OK};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (level_q == LVL_PT) begin
						// Leaf of a translate
						if (present) begin
							rsp_q <= '{host_addr: {ent_page, req_q.guest_addr[OFFS_W-1:0]},
								status: ST_OK};
						end else begin
							rsp_q <= '{host_addr: '0, status: ST_UNMAPPED};
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (present) begin
						// Follow the link, drop on a frame past the table
						if (link_bad) begin
							rsp_q   <= '{host_addr: '0, status: ST_UNMAPPED};
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							frame_q <= ent_page[FRAME_W-1:0];
							level_q <= level_q + 1'b1;
							state_q <= S_READ;
						end
					end else if (req_q.op == OP_XLATE) begin
						rsp_q   <= '{host_addr: '0, status: ST_UNMAPPED};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (pool_empty) begin
						rsp_q   <= '{host_addr: '0, status: ST_NOFRAME};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						// Allocate a fresh frame and advance into it
						frame_q <= nfree_q[FRAME_W-1:0];
						nfree_q <= nfree_q + 1'b1;
						level_q <= level_q + 1'b1;
						state_q <= S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* design/ept_ram.sv */
// Generic single-port RAM with registered read data.
// Parameters set word width and depth. No dependencies.
module ept_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* design/ept_chk.sv */
// Port-level checker for the translation table walker, bound to the top level.
// Depends on ept_pkg for the transaction structs and status codes.
module ept_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input ept_pkg::ept_req_t req,
	input logic              done,
	input ept_pkg::ept_rsp_t rsp
);
	import ept_pkg::*;

	// An accepted transaction makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after accepting a transaction");

	// A result never shows in the cycle after an accept
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result strobe right after accept");

	// A result ends the work: busy before, idle while shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("result strobe outside the end of a transaction");

	// Failed transactions carry a zero address, and status stays in range
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.host_addr == '0))
		else $error("nonzero address with error status");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.status == ST_OK || rsp.status == ST_UNMAPPED ||
			rsp.status == ST_NOFRAME))
		else $error("illegal status code");

endmodule

bind ept_four_level_map_and_walk ept_chk u_ept_chk (.*);

/* dv/ept_four_level_map_and_walk_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ept_four_level_map_and_walk: map and translate transactions
// checked against an in-bench copy of the four-level table and its frame allocator.
// Depends on design/ept_pkg.sv and design/ept_four_level_map_and_walk.sv.
module ept_four_level_map_and_walk_tb;
	import ept_pkg::*;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int RANDOM_ITEMS   = 1530;

	typedef struct {
		ept_req_t    req;
		int unsigned idle_pct;
		bit          drain;
	} stim_item_t;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	ept_req_t req    = '0;
	logic     busy;
	logic     done;
	ept_rsp_t rsp;

	stim_item_t  pending_items[$];
	ept_rsp_t    expected_rsp[$];
	bit          holding;
	int unsigned mismatches;
	int unsigned stall_cycles;

	// Shadow copy of the translation table and the bump allocator
	logic [ENTRY_W-1:0] shadow_table [TBL_DEPTH];
	int unsigned        next_frame;

	ept_four_level_map_and_walk uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Walk the shadow table for one transaction, allocating and writing as the block does
	function automatic ept_rsp_t walk_table(ept_req_t r);
		logic [ENTRY_W-1:0] ent;
		int unsigned        frame;
		int unsigned        idx;
		int unsigned        lvl;
		bit                 stop;
		ept_rsp_t           res;
		res = '0;
		res.status = ST_OK;
		frame = 0;
		stop = 1'b0;
		for (lvl = 0; lvl < 3 && !stop; lvl++) begin
			idx = 32'((r.guest_addr >> (39 - 9 * lvl)) & 48'h1FF);
			ent = shadow_table[frame * ENTRIES_PER_FRAME + idx];
			if (ent[2:0] != 3'b000) begin
				// a link past the table counts as not mapped
				if (ent[51:12] >= TABLE_FRAMES) begin
					res.status = ST_UNMAPPED;
					stop = 1'b1;
				end else begin
					frame = 32'(ent[51:12]);
				end
			end else if (r.op == OP_XLATE) begin
				res.status = ST_UNMAPPED;
				stop = 1'b1;
			end else if (next_frame >= TABLE_FRAMES) begin
				// links made at upper levels stay in place
				res.status = ST_NOFRAME;
				stop = 1'b1;
			end else begin
				shadow_table[frame * ENTRIES_PER_FRAME + idx] =
					BIT_R | BIT_W | BIT_X | BIT_UX | (64'(next_frame) << 12);
				frame = next_frame;
				next_frame++;
			end
		end
		if (!stop) begin
			idx = 32'(r.guest_addr[20:12]);
			if (r.op == OP_MAP) begin
				shadow_table[frame * ENTRIES_PER_FRAME + idx] =
					BIT_R | BIT_W | BIT_X | BIT_UX | BIT_IPAT |
					(r.write_back ? MT_WB : 64'h0) | {12'h0, r.host_page, 12'h0};
			end else begin
				ent = shadow_table[frame * ENTRIES_PER_FRAME + idx];
				if (ent[2:0] != 3'b000)
					res.host_addr = {ent[51:12], r.guest_addr[11:0]};
				else
					res.status = ST_UNMAPPED;
			end
		end
		return res;
	endfunction

	function automatic logic [GADDR_W-1:0] gaddr(int unsigned l0, int unsigned l1,
			int unsigned l2, int unsigned l3, int unsigned offs);
		return {9'(l0), 9'(l1), 9'(l2), 9'(l3), 12'(offs)};
	endfunction

	function automatic ept_req_t make_req(logic op, logic [GADDR_W-1:0] g,
			logic [PAGE_W-1:0] hp, logic wb);
		ept_req_t r;
		r.op = op;
		r.guest_addr = g;
		r.host_page = hp;
		r.write_back = wb;
		return r;
	endfunction

	task automatic add_item(ept_req_t r, int unsigned pct, bit drain);
		stim_item_t it;
		it.req = r;
		it.idle_pct = pct;
		it.drain = drain;
		pending_items.push_back(it);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Driver: present the next transaction at the falling edge, idling at random
	always @(negedge clk) begin
		if (arst_n && !holding) begin
			if (pending_items.size() > 0 &&
					!(pending_items[0].drain && expected_rsp.size() > 0) &&
					$urandom_range(99) >= pending_items[0].idle_pct) begin
				start <= 1'b1;
				req <= pending_items[0].req;
				holding = 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: check results, predict accepted transactions, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			stall_cycles++;
			if (done) begin
				stall_cycles = 0;
				if (expected_rsp.size() == 0) begin
					report_mismatch("unexpected result", 64'(rsp), 64'h0);
				end else begin
					ept_rsp_t want;
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 64'(rsp.status), 64'(want.status));
					if (rsp.host_addr !== want.host_addr)
						report_mismatch("host_addr", 64'(rsp.host_addr),
							64'(want.host_addr));
				end
			end
			if (start && !busy) begin
				stall_cycles = 0;
				expected_rsp.push_back(walk_table(req));
				void'(pending_items.pop_front());
				holding = 1'b0;
			end
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[ept_four_level_map_and_walk] ERROR");
			$finish;
		end
	end

	initial begin
		logic [26:0]        walk_prefixes [8];
		logic [8:0]         leaf_pool [4];
		logic [8:0]         leaf;
		logic [GADDR_W-1:0] g;
		logic [PAGE_W-1:0]  hp;
		logic               op;
		int unsigned        pct;
		bit                 drain;
		int                 n;

		foreach (shadow_table[i])
			shadow_table[i] = '0;
		next_frame = 1;
		holding = 1'b0;
		mismatches = 0;
		stall_cycles = 0;

		// Directed: empty table, extremes, remap, partial walks, frame exhaustion
		add_item(make_req(OP_XLATE, '0, '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_MAP, '0, '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_XLATE, '0, '0, 1'b0), 35, 1'b1);
		add_item(make_req(OP_XLATE, 48'hFFF, '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_MAP, '1, '1, 1'b1), 35, 1'b0);
		add_item(make_req(OP_XLATE, '1, '0, 1'b1), 35, 1'b0);
		add_item(make_req(OP_MAP, '0, 40'h12_3456_789A, 1'b1), 35, 1'b0);
		add_item(make_req(OP_XLATE, 48'h123, '1, 1'b0), 35, 1'b0);
		add_item(make_req(OP_XLATE, gaddr(0, 0, 0, 1, 0), '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_XLATE, gaddr(0, 0, 1, 0, 0), '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_XLATE, gaddr(0, 1, 0, 0, 0), '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_XLATE, gaddr(1, 0, 0, 0, 0), '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_MAP, gaddr(0, 0, 1, 5, 0), 40'hA5_A5A5_A5A5, 1'b0), 35, 1'b0);
		add_item(make_req(OP_XLATE, gaddr(0, 0, 1, 5, 'hABC), '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_MAP, gaddr('h1FF, 0, 0, 0, 0), 40'h5A_5A5A_5A5A, 1'b1),
			35, 1'b0);
		add_item(make_req(OP_MAP, gaddr(1, 0, 0, 0, 0), 40'h00_0000_0001, 1'b0), 35, 1'b0);
		add_item(make_req(OP_MAP, gaddr(1, 1, 0, 'h1FF, 0), 40'h80_0000_0000, 1'b1),
			35, 1'b0);
		add_item(make_req(OP_MAP, gaddr(2, 0, 0, 0, 0), 40'h33, 1'b1), 35, 1'b0);
		add_item(make_req(OP_MAP, gaddr(2, 0, 0, 0, 0), 40'h44, 1'b0), 35, 1'b0);
		add_item(make_req(OP_XLATE, gaddr(2, 0, 0, 0, 0), '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_XLATE, gaddr(1, 1, 0, 'h1FF, 'hFFF), '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_MAP, gaddr(3, 0, 0, 0, 0), 40'h55, 1'b1), 35, 1'b0);
		add_item(make_req(OP_XLATE, gaddr(3, 0, 0, 0, 0), '0, 1'b0), 35, 1'b0);
		add_item(make_req(OP_MAP, gaddr(0, 0, 0, 2, 0), 40'h66, 1'b0), 35, 1'b0);

		// Random: mostly walks down the paths built above, some free-form noise
		walk_prefixes[0] = {9'h000, 9'h000, 9'h000};
		walk_prefixes[1] = {9'h000, 9'h000, 9'h001};
		walk_prefixes[2] = {9'h1FF, 9'h1FF, 9'h1FF};
		walk_prefixes[3] = {9'h1FF, 9'h000, 9'h000};
		walk_prefixes[4] = {9'h001, 9'h000, 9'h000};
		walk_prefixes[5] = {9'h001, 9'h001, 9'h000};
		walk_prefixes[6] = {9'h002, 9'h000, 9'h000};
		walk_prefixes[7] = {9'h000, 9'h1FF, 9'h1FF};
		leaf_pool[0] = 9'h000;
		leaf_pool[1] = 9'h1FF;
		leaf_pool[2] = 9'h0AA;
		leaf_pool[3] = 9'($urandom);
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pct = (n < RANDOM_ITEMS / 3) ? 35 : (n < 2 * RANDOM_ITEMS / 3) ? 69 : 0;
			drain = (n == RANDOM_ITEMS / 3) || (n == 2 * RANDOM_ITEMS / 3) ||
				($urandom_range(49) == 0);
			if ($urandom_range(99) < 80) begin
				leaf = ($urandom_range(99) < 60) ? leaf_pool[$urandom_range(3)]
					: 9'($urandom);
				g = {walk_prefixes[$urandom_range(7)], leaf, 12'($urandom)};
			end else begin
				g = 48'({$urandom, $urandom});
			end
			case ($urandom_range(9))
				0:       hp = '0;
				1:       hp = '1;
				default: hp = 40'({$urandom, $urandom});
			endcase
			op = ($urandom_range(99) < 40) ? OP_MAP : OP_XLATE;
			add_item(make_req(op, g, hp, 1'($urandom_range(1))), pct, drain);
		end

		// Release reset at a falling edge; the clearing pass starts once reset is released
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Drain all transactions, then let the block settle
		while (pending_items.size() > 0 || expected_rsp.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("[ept_four_level_map_and_walk] OK");
		else
			$display("[ept_four_level_map_and_walk] ERROR");
		$finish;
	end

endmodule
